### design/pvkf_pkg.sv
// Package: shared types and constants for the position/velocity tracking filter.
`default_nettype none
package pvkf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COV_WIDTH = 48;
  localparam int XW = 32;
  localparam int OPW = 64;

  localparam logic signed [OPW-1:0] CMAX = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
  localparam logic signed [OPW-1:0] CMIN = -CMAX - 64'sd1;
  localparam logic signed [OPW-1:0] XMAX = 64'sd2147483647;
  localparam logic signed [OPW-1:0] XMIN = -64'sd2147483648;
  localparam logic signed [COV_WIDTH-1:0] ONE_C = COV_WIDTH'(1) << FRAC_BITS;

  localparam logic [1:0] KIND_PREDICT = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_IPOS  = 2'd1;
  localparam logic [1:0] REG_IVEL  = 2'd2;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    LIM_COV,
    LIM_X
  } lim_t;

  typedef struct packed {
    logic start;
    op_t  op;
    lim_t lim;
    logic half;   // extra shift for dt^2/2
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_CHECK,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

### design/pvkf_alu.sv
// Shared multi-cycle arithmetic unit: rounded multiply, saturating add/sub, divide.
`default_nettype none
module pvkf_alu
  import pvkf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire alu_cmd_t              cmd,
  input  wire logic signed [OPW-1:0] a,
  input  wire logic signed [OPW-1:0] b,
  output logic signed [OPW-1:0]      res,
  output alu_sts_t                   sts
);

  // Multiply accumulates four 32x32 partial products in turn; divide is restoring.
  localparam int DIVN = 128;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_FIN, A_DIV, A_DFIN, A_DONE} ast_t;

  ast_t              st_r, st_nxt;
  logic [63:0]       ma_r, mb_r;
  logic              neg_r;
  logic [127:0]      acc_r;
  logic [1:0]        pp_r;
  logic [6:0]        cnt_r;
  logic [63:0]       rem_r;
  logic [127:0]      num_r;
  logic              half_r;
  lim_t              lim_r;
  logic signed [OPW-1:0] res_r;
  logic              sat_r;

  logic [63:0]  mag_a, mag_b;
  logic [31:0]  pa, pb;
  logic [63:0]  pprod;
  logic [127:0] pshift;
  logic [64:0]  rem_sh;
  logic [127:0] rounded, shifted, quot;
  logic [63:0]  lim_pos, lim_neg;
  logic signed [64:0] sum65;
  logic [63:0]  lo_s, hi_s;

  assign mag_a = a[OPW-1] ? 64'(-a) : 64'(a);
  assign mag_b = b[OPW-1] ? 64'(-b) : 64'(b);

  always_comb begin
    pa = pp_r[0] ? ma_r[63:32] : ma_r[31:0];
    pb = pp_r[1] ? mb_r[63:32] : mb_r[31:0];
    pprod = {32'd0, pa} * {32'd0, pb};
    pshift = {64'd0, pprod} << (7'(pp_r[0]) * 7'd32 + 7'(pp_r[1]) * 7'd32);
    rem_sh = {rem_r, num_r[127]};
  end

  always_comb begin
    lo_s = (lim_r == LIM_X) ? 64'(XMIN) : 64'(CMIN);
    hi_s = (lim_r == LIM_X) ? 64'(XMAX) : 64'(CMAX);
    lim_pos = hi_s;
    lim_neg = 64'(-$signed(lo_s));
    rounded = acc_r + (128'd1 << (half_r ? FRAC_BITS : FRAC_BITS - 1));
    shifted = half_r ? (rounded >> (FRAC_BITS + 1)) : (rounded >> FRAC_BITS);
    // divide rounding: rem >= d - rem
    quot = (rem_r >= (mb_r - rem_r)) ? num_r + 128'd1 : num_r;
    sum65 = (cmd.op == OP_SUB) ? 65'(a) - 65'(b) : 65'(a) + 65'(b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.op)
            OP_MUL:  st_nxt = A_MUL;
            OP_DIV:  st_nxt = A_DIV;
            default: st_nxt = A_DONE;
          endcase
        end
      end
      A_MUL:  if (pp_r == 2'd3) st_nxt = A_FIN;
      A_FIN:  st_nxt = A_DONE;
      A_DIV:  if (cnt_r == 7'(DIVN - 1)) st_nxt = A_DFIN;
      A_DFIN: st_nxt = A_DONE;
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  function automatic logic [64:0] clampm(input logic neg, input logic [127:0] m,
                                         input logic [63:0] lp, input logic [63:0] ln);
    logic [63:0] lim;
    begin
      lim = neg ? ln : lp;
      if (m[127:64] != 64'd0 || m[63:0] > lim) clampm = {1'b1, neg ? 64'(-ln) : lp};
      else clampm = {1'b0, neg ? 64'(-m[63:0]) : m[63:0]};
    end
  endfunction

  // Saturating add/sub is computed and registered in the issue cycle.
  task automatic addsub_sat(input logic signed [64:0] s, input lim_t l);
    logic signed [64:0] lo65, hi65;
    begin
      lo65 = (l == LIM_X) ? 65'(XMIN) : 65'(CMIN);
      hi65 = (l == LIM_X) ? 65'(XMAX) : 65'(CMAX);
      if (s > hi65) begin
        res_r <= 64'(hi65);
        sat_r <= 1'b1;
      end else if (s < lo65) begin
        res_r <= 64'(lo65);
        sat_r <= 1'b1;
      end else begin
        res_r <= 64'(s);
        sat_r <= 1'b0;
      end
    end
  endtask

  logic [64:0] clm, cld;
  assign clm = clampm(neg_r, shifted, lim_pos, lim_neg);
  assign cld = clampm(neg_r, quot, lim_pos, lim_neg);

  always_ff @(posedge clk) begin
    unique case (st_r)
      A_IDLE: begin
        if (cmd.start) begin
          ma_r   <= mag_a;
          mb_r   <= (cmd.op == OP_DIV) ? 64'(b) : mag_b;
          neg_r  <= (cmd.op == OP_DIV) ? a[OPW-1] : (a[OPW-1] ^ b[OPW-1]);
          half_r <= cmd.half;
          lim_r  <= cmd.lim;
          acc_r  <= '0;
          pp_r   <= '0;
          cnt_r  <= '0;
          rem_r  <= '0;
          num_r  <= {64'd0, mag_a} << FRAC_BITS;
          if (cmd.op == OP_ADD || cmd.op == OP_SUB) begin
            addsub_sat(sum65, cmd.lim);
          end else begin
            sat_r <= 1'b0;
          end
        end
      end
      A_MUL: begin
        acc_r <= acc_r + pshift;
        pp_r  <= pp_r + 2'd1;
      end
      A_FIN: begin
        res_r <= clm[63:0];
        sat_r <= clm[64];
      end
      A_DIV: begin
        // num_r shifts out numerator bits and collects quotient bits
        if (rem_sh >= {1'b0, mb_r}) begin
          rem_r <= 64'(rem_sh - {1'b0, mb_r});
          num_r <= {num_r[126:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          num_r <= {num_r[126:0], 1'b0};
        end
        cnt_r <= cnt_r + 7'd1;
      end
      A_DFIN: begin
        res_r <= cld[63:0];
        sat_r <= cld[64];
      end
      default: ;
    endcase
  end

  assign res      = res_r;
  assign sts.done = (st_r == A_DONE);
  assign sts.sat  = sat_r;

endmodule
`default_nettype wire

### design/position_velocity_kalman_filter_top.sv
// Top level: constant-velocity tracking filter with stream ports and register port.
`default_nettype none
// Two-state (position, velocity) fixed-point tracker. Each input transfer is a
// predict (kind 0), a measurement update (kind 1) or a restart from the
// initial-state registers (kind 2); every transfer yields exactly one result
// transfer carrying position, velocity, clamped P00 and a status code. All
// arithmetic runs through one shared unit stepped by a microcode sequencer:
// a multiply accumulates four 32x32 partial products, then rounds and clamps;
// an add or subtract saturates, and a divide runs 128 restoring steps.
// A predict issues 22 operations (12 multiplies, 10 adds); an update issues
// 2 divides plus 13 other operations, or only its first add when it is
// skipped; restart and the unused kind issue none. in_tready is high only
// while the sequencer is idle; the result sits in an output register until
// taken, and a stalled result channel holds the sequencer until it is free.
module position_velocity_kalman_filter_top
  import pvkf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: time_step[31:0], measured_position[63:32], measurement_variance[95:64]
  input  wire logic [95:0]  in_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: position[31:0], velocity[63:32], position_variance[110:64], zero pad
  output logic [111:0]      out_tdata,
  // tuser: status[1:0]
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Scratch register file indexes.
  localparam int NR = 16;
  localparam logic [3:0] R_P0 = 4'd0, R_P1 = 4'd1, R_P2 = 4'd2, R_P3 = 4'd3,
    R_X = 4'd4, R_V = 4'd5, R_DT = 4'd6, R_Z = 4'd7, R_R = 4'd8, R_AN = 4'd9,
    R_T0 = 4'd10, R_T1 = 4'd11, R_T2 = 4'd12, R_T3 = 4'd13, R_T4 = 4'd14, R_T5 = 4'd15;

  typedef struct packed {
    op_t        op;
    lim_t       lim;
    logic       half;
    logic [3:0] ra;
    logic [3:0] rb;
    logic [3:0] rd;
  } uop_t;

  function automatic uop_t u(op_t o, lim_t l, logic h, logic [3:0] a, logic [3:0] b,
                             logic [3:0] d);
    uop_t x;
    begin
      x.op = o; x.lim = l; x.half = h; x.ra = a; x.rb = b; x.rd = d;
      u = x;
    end
  endfunction

  // Predict program (22 ops). T0 = cm(V,dt) then X += T0.
  function automatic uop_t pred_rom(input logic [4:0] i);
    uop_t r;
    begin
      case (i)
        5'd0:  r = u(OP_MUL, LIM_COV, 1'b0, R_V, R_DT, R_T0);
        5'd1:  r = u(OP_ADD, LIM_X, 1'b0, R_X, R_T0, R_X);
        5'd2:  r = u(OP_MUL, LIM_COV, 1'b1, R_DT, R_DT, R_T1);    // g0
        5'd3:  r = u(OP_ADD, LIM_COV, 1'b0, R_DT, R_Z, R_T2);     // g1 (Z holds 0)
        5'd4:  r = u(OP_MUL, LIM_COV, 1'b0, R_AN, R_AN, R_T3);    // q
        5'd5:  r = u(OP_MUL, LIM_COV, 1'b0, R_T1, R_T3, R_T4);    // t
        5'd6:  r = u(OP_MUL, LIM_COV, 1'b0, R_T1, R_T4, R_T1);    // q00
        5'd7:  r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_T4, R_T4);    // q01
        5'd8:  r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_T3, R_T3);
        5'd9:  r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_T3, R_T3);    // q11
        5'd10: r = u(OP_MUL, LIM_COV, 1'b0, R_DT, R_P2, R_T0);
        5'd11: r = u(OP_ADD, LIM_COV, 1'b0, R_P0, R_T0, R_T0);    // a00
        5'd12: r = u(OP_MUL, LIM_COV, 1'b0, R_DT, R_P3, R_T2);
        5'd13: r = u(OP_ADD, LIM_COV, 1'b0, R_P1, R_T2, R_T2);    // a01
        5'd14: r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_DT, R_T5);
        5'd15: r = u(OP_ADD, LIM_COV, 1'b0, R_T0, R_T5, R_T0);    // n00
        5'd16: r = u(OP_MUL, LIM_COV, 1'b0, R_P3, R_DT, R_T5);
        5'd17: r = u(OP_ADD, LIM_COV, 1'b0, R_P2, R_T5, R_T5);    // n10
        5'd18: r = u(OP_ADD, LIM_COV, 1'b0, R_T0, R_T1, R_P0);
        5'd19: r = u(OP_ADD, LIM_COV, 1'b0, R_T2, R_T4, R_P1);
        5'd20: r = u(OP_ADD, LIM_COV, 1'b0, R_T5, R_T4, R_P2);
        5'd21: r = u(OP_ADD, LIM_COV, 1'b0, R_P3, R_T3, R_P3);
        default: r = u(OP_ADD, LIM_COV, 1'b0, R_P3, R_Z, R_P3);
      endcase
      pred_rom = r;
    end
  endfunction
  localparam logic [4:0] PRED_LEN = 5'd22;

  // Update program: op0 computes S, then check, then the rest.
  function automatic uop_t upd_rom(input logic [4:0] i);
    uop_t r;
    begin
      case (i)
        5'd0:  r = u(OP_ADD, LIM_COV, 1'b0, R_P0, R_R, R_T0);     // S
        5'd1:  r = u(OP_DIV, LIM_COV, 1'b0, R_P0, R_T0, R_T1);    // k0
        5'd2:  r = u(OP_DIV, LIM_COV, 1'b0, R_P2, R_T0, R_T2);    // k1
        5'd3:  r = u(OP_MUL, LIM_COV, 1'b0, R_T1, R_Z, R_T3);     // Z holds y
        5'd4:  r = u(OP_ADD, LIM_X, 1'b0, R_X, R_T3, R_X);
        5'd5:  r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_Z, R_T3);
        5'd6:  r = u(OP_ADD, LIM_X, 1'b0, R_V, R_T3, R_V);
        5'd7:  r = u(OP_MUL, LIM_COV, 1'b0, R_T1, R_P0, R_T3);
        5'd8:  r = u(OP_MUL, LIM_COV, 1'b0, R_T1, R_P1, R_T4);
        5'd9:  r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_P0, R_T5);
        5'd10: r = u(OP_MUL, LIM_COV, 1'b0, R_T2, R_P1, R_T0);
        5'd11: r = u(OP_SUB, LIM_COV, 1'b0, R_P0, R_T3, R_P0);
        5'd12: r = u(OP_SUB, LIM_COV, 1'b0, R_P1, R_T4, R_P1);
        5'd13: r = u(OP_SUB, LIM_COV, 1'b0, R_P2, R_T5, R_P2);
        default: r = u(OP_SUB, LIM_COV, 1'b0, R_P3, R_T0, R_P3);
      endcase
      upd_rom = r;
    end
  endfunction
  localparam logic [4:0] UPD_LEN = 5'd15;

  state_t st_r, st_nxt;
  logic signed [OPW-1:0] rf_r [NR];
  logic [4:0]  pc_r, pc_nxt;
  logic [1:0]  kind_r;
  logic        sat_r, sat_nxt;
  logic [1:0]  status_r;
  logic [31:0] accel_r, ipos_r, ivel_r;
  logic        out_valid_r;
  logic [111:0] out_data_r;
  logic [1:0]  out_user_r;

  uop_t      uop;
  alu_cmd_t  cmd;
  alu_sts_t  asts;
  logic signed [OPW-1:0] alu_res;
  logic [4:0] prog_len;
  logic       in_fire, cfg_wr;
  logic signed [OPW-1:0] p00c;

  assign uop      = (kind_r == KIND_PREDICT) ? pred_rom(pc_r) : upd_rom(pc_r);
  assign prog_len = (kind_r == KIND_PREDICT) ? PRED_LEN : UPD_LEN;

  assign cmd.start = (st_r == S_ISSUE);
  assign cmd.op    = uop.op;
  assign cmd.lim   = uop.lim;
  assign cmd.half  = uop.half;

  pvkf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .a     (rf_r[uop.ra]),
    .b     (rf_r[uop.rb]),
    .res   (alu_res),
    .sts   (asts)
  );

  assign in_tready = (st_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ACCEL: cfg_prdata = accel_r;
      REG_IPOS:  cfg_prdata = ipos_r;
      REG_IVEL:  cfg_prdata = ivel_r;
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 32'd65536;
      ipos_r  <= '0;
      ivel_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ACCEL: accel_r <= cfg_pwdata;
        REG_IPOS:  ipos_r  <= cfg_pwdata;
        REG_IVEL:  ivel_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Sequencer: issue one op, wait for the unit, write back, advance.
  always_comb begin
    st_nxt = st_r;
    pc_nxt = pc_r;
    sat_nxt = sat_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          pc_nxt = '0;
          sat_nxt = 1'b0;
          if (in_tuser == KIND_PREDICT || in_tuser == KIND_UPDATE) st_nxt = S_ISSUE;
          else st_nxt = S_OUT;
        end
      end
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT: begin
        if (asts.done) begin
          sat_nxt = sat_r | asts.sat;
          pc_nxt = pc_r + 5'd1;
          if (kind_r == KIND_UPDATE && pc_r == 5'd0) st_nxt = S_CHECK;
          else if (pc_r + 5'd1 == prog_len) st_nxt = S_OUT;
          else st_nxt = S_ISSUE;
        end
      end
      S_CHECK: st_nxt = (rf_r[R_T0] <= 0) ? S_OUT : S_ISSUE;
      S_OUT: if (!out_valid_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      sat_r <= sat_nxt;
    end
  end

  // Working registers and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r[R_P0] <= 64'(ONE_C);
      rf_r[R_P1] <= '0;
      rf_r[R_P2] <= '0;
      rf_r[R_P3] <= 64'(ONE_C);
      rf_r[R_X]  <= '0;
      rf_r[R_V]  <= '0;
      status_r   <= ST_OK;
    end else begin
      if (in_fire) begin
        kind_r     <= in_tuser;
        status_r   <= ST_OK;
        rf_r[R_DT] <= 64'({32'd0, in_tdata[31:0]});
        rf_r[R_R]  <= 64'({32'd0, in_tdata[95:64]});
        rf_r[R_AN] <= 64'({32'd0, accel_r});
        // Z holds zero for predict, the innovation for update.
        if (in_tuser == KIND_UPDATE)
          rf_r[R_Z] <= 64'(signed'(in_tdata[63:32])) - rf_r[R_X];
        else
          rf_r[R_Z] <= '0;
        if (in_tuser == KIND_RESTART) begin
          rf_r[R_X]  <= 64'(signed'(ipos_r));
          rf_r[R_V]  <= 64'(signed'(ivel_r));
          rf_r[R_P0] <= 64'(ONE_C);
          rf_r[R_P1] <= '0;
          rf_r[R_P2] <= '0;
          rf_r[R_P3] <= 64'(ONE_C);
        end
      end
      if (st_r == S_WAIT && asts.done) rf_r[uop.rd] <= alu_res;
      if (st_r == S_CHECK && rf_r[R_T0] <= 0) status_r <= ST_SKIP;
    end
  end

  assign p00c = rf_r[R_P0];

  // Load the result register when it is free or being taken; else drop valid on a take.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r[31:0]   <= rf_r[R_X][31:0];
        out_data_r[63:32]  <= rf_r[R_V][31:0];
        out_data_r[110:64] <= p00c[OPW-1] ? 47'd0 :
          ((p00c > 64'sh7FFFFFFFFFFF) ? {47{1'b1}} : p00c[46:0]);
        out_data_r[111]    <= 1'b0;
        out_user_r <= (status_r == ST_SKIP) ? ST_SKIP : (sat_r ? ST_SAT : ST_OK);
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");
  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_SAT || out_tuser == ST_SKIP))
    else $error("bad status");
`endif

endmodule
`default_nettype wire
